### hw/rtl/wwss_pkg.sv
// ----------------------------------------------------------------------------
// wwss_pkg: shared types and constants for the whole-word substring search
// payload structs, register indexes, cell controls and byte helpers
// ----------------------------------------------------------------------------
package wwss_pkg;

  localparam int unsigned PatternMax = 8;
  localparam int unsigned TextMax    = 65536;
  localparam int unsigned MaxStart   = 65535;
  localparam int unsigned PosCap     = TextMax + PatternMax + 1;
  localparam int unsigned PosW       = $clog2(PosCap + 1);
  localparam int unsigned IdxW       = (PatternMax > 1) ? $clog2(PatternMax) : 1;
  localparam int unsigned FoldDelta  = 32;

  typedef enum logic [2:0] {
    CfgPatternBytes  = 3'd0,
    CfgPatternLength = 3'd1,
    CfgMatchCase     = 3'd2,
    CfgWholeWord     = 3'd3,
    CfgStartOffset   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic        found;
    logic [15:0] match_start;
    logic [16:0] match_end;
  } out_req_t;

  // controls shared by every cell of the window
  typedef struct packed {
    logic shift;
    logic clear;
    logic fold;
  } cell_ctrl_t;

  // exact compare, or a difference of 32 either way when folding
  function automatic logic bytes_agree(logic [7:0] t, logic [7:0] q, logic fold);
    logic [8:0] t_up;
    logic [8:0] q_up;
    t_up = {1'b0, t} + 9'(FoldDelta);
    q_up = {1'b0, q} + 9'(FoldDelta);
    return (t == q) || (fold && ((t_up == {1'b0, q}) || (q_up == {1'b0, t})));
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return ((b >= 8'd65) && (b <= 8'd90)) || ((b >= 8'd97) && (b <= 8'd122));
  endfunction

endpackage

### hw/rtl/whole_word_substring_search.sv
// ----------------------------------------------------------------------------
// whole_word_substring_search: streaming first-match pattern search
// finds the first start position of a pattern of up to eight bytes in a
// byte stream, with optional case folding and whole-word check
// ----------------------------------------------------------------------------
// usage
//   cfg channel: write pattern bytes, length, match_case, whole_word and
//     start_offset by index while the block is idle; cfg_ready_o is always high
//   input channel: one text byte per request, last_byte marks the end of a text
//   output channel: one request per text, sent after its last byte, holding
//     found, match_start and match_end (both zero when nothing matched)
// timing
//   one text byte per cycle, sustained while no result is held up; the compare
//   over the window cells is done in the cycle a byte is accepted, so the
//   result of a text is valid in the cycle after its last byte is accepted
//   a text byte is taken when the output register is empty or the receiver
//   takes the waiting result at the same edge
// reset
//   registers return to pattern 0, length 1, exact compare, no word check,
//   offset 0; window, position and match state clear, no result pending
//   a stalled receiver holds the result, and while it waits the input
//   channel backs up on every byte
// ----------------------------------------------------------------------------
module whole_word_substring_search
  import wwss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // text bytes
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_req_t     in_data_i,
  // search results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_req_t    out_data_o
);

  // configuration registers
  logic [63:0] pattern_bytes_q;
  logic [3:0]  pattern_length_q;
  logic        match_case_q;
  logic        whole_word_q;
  logic [15:0] start_offset_q;

  // per-text search state
  logic [PosW-1:0] pos_q, pos_d;
  logic            seen_q, seen_d;
  logic [15:0]     first_q, first_d;

  // result register
  logic     out_valid_q, out_valid_d;
  out_req_t out_q, out_d;

  logic in_acc;
  logic last_acc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign last_acc    = in_acc && in_data_i.last_byte;

  // register writes, indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_bytes_q  <= '0;
      pattern_length_q <= 4'd1;
      match_case_q     <= 1'b1;
      whole_word_q     <= 1'b0;
      start_offset_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgPatternBytes:  pattern_bytes_q  <= cfg_data_i;
        CfgPatternLength: pattern_length_q <= cfg_data_i[3:0];
        CfgMatchCase:     match_case_q     <= cfg_data_i[0];
        CfgWholeWord:     whole_word_q     <= cfg_data_i[0];
        CfgStartOffset:   start_offset_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // length in use: zero counts as one, above the cell count clips
  logic [3:0] len;
  always_comb begin
    if (pattern_length_q == 4'd0) begin
      len = 4'd1;
    end else if (pattern_length_q > 4'(PatternMax)) begin
      len = 4'(PatternMax);
    end else begin
      len = pattern_length_q;
    end
  end

  logic [7:0] pat [PatternMax];
  for (genvar j = 0; j < PatternMax; j++) begin : g_pat
    assign pat[j] = pattern_bytes_q[8*j +: 8];
  end

  // window cells, cell 0 holds the newest byte seen before this request
  // alignment a: pattern ends in cell 0, the incoming byte follows it
  // alignment b: pattern ends on the incoming byte (end of text only)
  cell_ctrl_t      cell_ctrl;
  logic [7:0]      cell_byte [PatternMax];
  logic [PatternMax-1:0] agree_a, agree_b, use_a, use_b;

  assign cell_ctrl.shift = in_acc;
  assign cell_ctrl.clear = last_acc;
  assign cell_ctrl.fold  = !match_case_q;

  for (genvar k = 0; k < PatternMax; k++) begin : g_cell
    logic [3:0] idx_a;
    logic [3:0] idx_b;
    logic [7:0] byte_in;

    assign idx_a    = len - 4'd1 - 4'(k);
    assign idx_b    = len - 4'd2 - 4'(k);
    assign use_a[k] = 4'(k) < len;
    assign use_b[k] = (4'(k) + 4'd2) <= len;

    if (k == 0) begin : g_head
      assign byte_in = in_data_i.text_byte;
    end else begin : g_link
      assign byte_in = cell_byte[k-1];
    end

    wwss_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cell_ctrl),
      .byte_i    (byte_in),
      .pat_a_i   (pat[idx_a[IdxW-1:0]]),
      .pat_b_i   (pat[idx_b[IdxW-1:0]]),
      .byte_o    (cell_byte[k]),
      .agree_a_o (agree_a[k]),
      .agree_b_o (agree_b[k])
    );
  end

  // candidate starts and their checks
  logic [3:0]      len_m1;
  logic [PosW-1:0] len_w, start_a, start_b, pos_inc;
  logic            bytes_a, bytes_b, hit_a, hit_b, next_letter;

  assign len_m1      = len - 4'd1;
  assign len_w       = PosW'(len);
  assign pos_inc     = pos_q + PosW'(1);
  assign start_a     = pos_q - len_w;
  assign start_b     = pos_inc - len_w;
  assign next_letter = is_letter(in_data_i.text_byte);
  assign bytes_a     = &(agree_a | ~use_a);
  assign bytes_b     = (&(agree_b | ~use_b)) &&
                       bytes_agree(in_data_i.text_byte, pat[len_m1[IdxW-1:0]],
                                   !match_case_q);

  function automatic logic start_ok(logic [PosW-1:0] s, logic [15:0] offs);
    return (32'(s) >= 32'(offs)) && (32'(s) < TextMax) && (32'(s) <= MaxStart);
  endfunction

  assign hit_a = (pos_q >= len_w) && bytes_a && start_ok(start_a, start_offset_q) &&
                 !(whole_word_q && next_letter);
  assign hit_b = in_data_i.last_byte && (pos_inc >= len_w) && bytes_b &&
                 start_ok(start_b, start_offset_q);

  // match state and position
  always_comb begin
    pos_d       = pos_q;
    seen_d      = seen_q;
    first_d     = first_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (in_acc) begin
      if (!seen_q && hit_a) begin
        seen_d  = 1'b1;
        first_d = start_a[15:0];
      end else if (!seen_q && hit_b) begin
        seen_d  = 1'b1;
        first_d = start_b[15:0];
      end
      if (32'(pos_q) < PosCap) begin
        pos_d = pos_inc;
      end
      if (in_data_i.last_byte) begin
        out_valid_d       = 1'b1;
        out_d.found       = seen_d;
        out_d.match_start = seen_d ? first_d : 16'd0;
        out_d.match_end   = seen_d ? ({1'b0, first_d} + 17'(len)) : 17'd0;
        // next text starts from a clean slate
        pos_d   = '0;
        seen_d  = 1'b0;
        first_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      seen_q      <= 1'b0;
      first_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      seen_q      <= seen_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a miss reports zero positions
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.found |-> out_q.match_start == '0 && out_q.match_end == '0)
    else $error("miss result carries nonzero positions");

  // a hit ends after it starts
  a_hit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.found |-> {1'b0, out_q.match_start} < out_q.match_end)
    else $error("match end not after match start");

  // end of text restarts the search state
  a_text_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_acc |=> pos_q == '0 && !seen_q && out_valid_q)
    else $error("search state not cleared after last byte");

  // input only backs up behind a pending result
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_q && !out_ready_i)
    else $error("input stalled without a pending result");

  // position counter never runs past its cap
  a_pos_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) <= PosCap)
    else $error("byte position past cap");

endmodule

### hw/rtl/wwss_cell.sv
// ----------------------------------------------------------------------------
// wwss_cell: one byte of the text window
// holds a byte, passes it on to the next cell and compares it to two
// pattern bytes, one per candidate alignment
// ----------------------------------------------------------------------------
module wwss_cell
  import wwss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] pat_a_i,
  input  logic [7:0] pat_b_i,
  output logic [7:0] byte_o,
  output logic       agree_a_o,
  output logic       agree_b_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clear) begin
      byte_d = '0;
    end else if (ctrl_i.shift) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o    = byte_q;
  assign agree_a_o = bytes_agree(byte_q, pat_a_i, ctrl_i.fold);
  assign agree_b_o = bytes_agree(byte_q, pat_b_i, ctrl_i.fold);

endmodule

### tb/search_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// search_result_checker: prediction and compare for the substring search
// follows register writes and accepted text bytes with its own window model,
// and checks every result request against the oldest predicted one
// ----------------------------------------------------------------------------
module search_result_checker
  import wwss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_req_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_req_t    out_data_i,
  output int unsigned mismatch_count_o,
  output int unsigned results_due_o,
  output int unsigned results_checked_o,
  output int unsigned matches_found_o
);

  localparam int unsigned WinDepth   = PatternMax + 1;
  localparam int unsigned MaxReports = 10;

  // shadow registers
  logic [63:0] pat_bytes;
  logic [3:0]  pat_len;
  logic        exact_case;
  logic        word_only;
  logic [15:0] first_pos;

  // per-text search state
  logic [7:0]  window [WinDepth];
  int unsigned text_pos;
  bit          hit;
  int unsigned hit_start;

  out_req_t    search_reports [$];

  function automatic bit is_alpha(logic [7:0] b);
    return (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122);
  endfunction

  function automatic bit bytes_equivalent(logic [7:0] t, logic [7:0] q);
    int unsigned ti;
    int unsigned qi;
    ti = t;
    qi = q;
    if (ti == qi) return 1'b1;
    return !exact_case && ((ti + FoldDelta == qi) || (qi + FoldDelta == ti));
  endfunction

  function automatic int unsigned pattern_span();
    if (pat_len == 0) return 1;
    if (pat_len > PatternMax) return PatternMax;
    return pat_len;
  endfunction

  // first pattern byte at window entry top, last at top - span + 1
  function automatic bit window_holds_match(int unsigned top, int unsigned span,
                                            int unsigned start, bit followed,
                                            logic [7:0] next_b);
    int unsigned i;
    if (start < first_pos || start >= TextMax || start > MaxStart) return 1'b0;
    for (i = 0; i < span; i++) begin
      if (!bytes_equivalent(window[top - i], pat_bytes[8*i +: 8])) return 1'b0;
    end
    if (word_only && followed && is_alpha(next_b)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void clear_text();
    int unsigned i;
    for (i = 0; i < WinDepth; i++) window[i] = '0;
    text_pos  = 0;
    hit       = 1'b0;
    hit_start = 0;
  endfunction

  function automatic void take_byte(in_req_t r);
    int unsigned span;
    int unsigned i;
    out_req_t    rep;
    span = pattern_span();
    for (i = WinDepth - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = r.text_byte;
    // match that ends on the byte before, this byte follows it
    if (!hit && text_pos >= span &&
        window_holds_match(span, span, text_pos - span, 1'b1, r.text_byte)) begin
      hit       = 1'b1;
      hit_start = text_pos - span;
    end
    // match that ends on the final byte, end of text follows it
    if (r.last_byte && !hit && text_pos + 1 >= span &&
        window_holds_match(span - 1, span, text_pos + 1 - span, 1'b0, 8'h00)) begin
      hit       = 1'b1;
      hit_start = text_pos + 1 - span;
    end
    if (text_pos < PosCap) text_pos++;
    if (r.last_byte) begin
      rep.found       = hit;
      rep.match_start = hit ? 16'(hit_start) : '0;
      rep.match_end   = hit ? 17'(hit_start + span) : '0;
      search_reports.push_back(rep);
      clear_text();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    out_req_t oldest;
    if (!rst_ni) begin
      pat_bytes  = '0;
      pat_len    = 4'd1;
      exact_case = 1'b1;
      word_only  = 1'b0;
      first_pos  = '0;
      clear_text();
      search_reports.delete();
      mismatch_count_o  = 0;
      results_checked_o = 0;
      matches_found_o   = 0;
    end else begin
      // a result can never belong to a byte taken at the same edge
      if (out_valid_i && out_ready_i) begin
        results_checked_o++;
        if (search_reports.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= MaxReports)
            $display("[%0t] result with no text pending: found=%0b start=%0d end=%0d",
                     $realtime, out_data_i.found, out_data_i.match_start,
                     out_data_i.match_end);
        end else begin
          oldest = search_reports.pop_front();
          if (oldest.found) matches_found_o++;
          if (out_data_i.found !== oldest.found ||
              out_data_i.match_start !== oldest.match_start ||
              out_data_i.match_end !== oldest.match_end) begin
            mismatch_count_o++;
            if (mismatch_count_o <= MaxReports)
              $display({"[%0t] result mismatch: expected found=%0b start=%0d end=%0d,",
                        " got found=%0b start=%0d end=%0d"},
                       $realtime, oldest.found, oldest.match_start, oldest.match_end,
                       out_data_i.found, out_data_i.match_start, out_data_i.match_end);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CfgPatternBytes:  pat_bytes  = cfg_data_i;
          CfgPatternLength: pat_len    = cfg_data_i[3:0];
          CfgMatchCase:     exact_case = cfg_data_i[0];
          CfgWholeWord:     word_only  = cfg_data_i[0];
          CfgStartOffset:   first_pos  = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) take_byte(in_data_i);
    end
    results_due_o = search_reports.size();
  end

endmodule

### tb/tb_whole_word_substring_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_whole_word_substring_search: stimulus and verdict for the pattern search
// drives register settings, text streams and result back-pressure; the
// search_result_checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_whole_word_substring_search;
  import wwss_pkg::*;

  localparam int unsigned RandomBytes    = 1600;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned CycleLimit     = 1000000;
  localparam int unsigned CfgIndexTop    = (1 << 3) - 1;

  // clock, reset and block ports, all at known values from time zero
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_req_t     in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_req_t    out_data_o;

  // checker results
  int unsigned mismatches;
  int unsigned results_due;
  int unsigned results_checked;
  int unsigned matches_found;

  // settings as last written, used to plant the pattern in random text
  logic [63:0] cur_pattern = '0;
  logic [3:0]  cur_len     = 4'd1;

  // idling control, shared with the receiver process
  bit          quiet_sender   = 1'b0;
  bit          quiet_receiver = 1'b0;
  bit          long_hold_req  = 1'b0;

  int unsigned bytes_sent      = 0;
  int unsigned texts_sent      = 0;
  int unsigned settings_used   = 1;
  int unsigned long_holds_done = 0;
  int unsigned cycle_count     = 0;

  whole_word_substring_search dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  search_result_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .in_data_i         (in_data_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_data_i        (out_data_o),
    .mismatch_count_o  (mismatches),
    .results_due_o     (results_due),
    .results_checked_o (results_checked),
    .matches_found_o   (matches_found)
  );

  // 20 ns clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // hard stop in case the handshakes hang
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, results_due);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // helpers for building settings and text
  // ---------------------------------------------------------------------------

  // pattern length as the block applies it: zero acts as one, above max clamps
  function automatic int unsigned usable_span();
    if (cur_len == 0) return 1;
    if (cur_len > PatternMax) return PatternMax;
    return cur_len;
  endfunction

  // first character in the lowest byte
  function automatic logic [63:0] pack_pattern(string s);
    logic [63:0] p;
    int unsigned i;
    p = '0;
    for (i = 0; i < s.len(); i++) p[8*i +: 8] = s[i];
    return p;
  endfunction

  // sometimes shift a byte by 32 so that folded compares get exercised
  function automatic logic [7:0] fold_maybe(logic [7:0] b);
    if ($urandom_range(0, 2) == 0) begin
      if (b >= 8'd32 && ($urandom_range(0, 1) == 0 || b > 8'd223)) return b - 8'd32;
      if (b <= 8'd223) return b + 8'd32;
    end
    return b;
  endfunction

  function automatic logic [7:0] any_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
  endfunction

  // text filler: raw bytes, letters, punctuation and pieces of the pattern
  function automatic logic [7:0] filler_byte();
    int unsigned k;
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 255));
      1: return any_letter();
      2: return 8'($urandom_range(32, 64));
      default: begin
        k = $urandom_range(0, usable_span() - 1);
        return fold_maybe(cur_pattern[8*k +: 8]);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers: inputs change on the falling edge, handshakes are
  // sampled on the rising edge
  // ---------------------------------------------------------------------------

  // one text byte; valid stays up between back-to-back requests
  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    gap = quiet_sender ? 0 : $urandom_range(0, 10);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{text_byte: b, last_byte: last};
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    if (last) texts_sent++;
  endtask

  task automatic send_string(string s);
    int unsigned i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // random text, most of the time with the pattern planted somewhere
  task automatic send_random_text(int unsigned len);
    logic [7:0]  text [$];
    int unsigned span;
    int unsigned at;
    int unsigned i;
    span = usable_span();
    for (i = 0; i < len; i++) text.push_back(filler_byte());
    if (len >= span && $urandom_range(0, 9) < 7) begin
      at = $urandom_range(0, len - span);
      for (i = 0; i < span; i++) text[at + i] = fold_maybe(cur_pattern[8*i +: 8]);
    end
    for (i = 0; i < len; i++) send_byte(text[i], i == len - 1);
  endtask

  // wait until every text has its result, then let the block go quiet
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (results_due != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // cfg valid is left high between writes, the caller lowers it
  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // full register set, written only once the block is idle; narrow fields
  // carry random junk in the unused upper bits
  task automatic set_search(logic [63:0] pattern, logic [3:0] len, logic exact,
                            logic word, logic [15:0] offset);
    logic [63:0] junk;
    settle();
    write_reg(CfgPatternBytes, pattern);
    junk = {$urandom, $urandom};
    write_reg(CfgPatternLength, {junk[63:4], len});
    junk = {$urandom, $urandom};
    write_reg(CfgMatchCase, {junk[63:1], exact});
    junk = {$urandom, $urandom};
    write_reg(CfgWholeWord, {junk[63:1], word});
    junk = {$urandom, $urandom};
    write_reg(CfgStartOffset, {junk[63:16], offset});
    // writes to the unassigned indexes must leave every setting alone
    if ($urandom_range(0, 3) == 0)
      write_reg(3'($urandom_range(int'(CfgStartOffset) + 1, CfgIndexTop)),
                {$urandom, $urandom});
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_pattern = pattern;
    cur_len     = len;
    settings_used++;
  endtask

  task automatic random_search();
    logic [63:0] pat;
    int unsigned len;
    int unsigned off;
    int unsigned i;
    for (i = 0; i < PatternMax; i++)
      pat[8*i +: 8] = ($urandom_range(0, 4) == 0) ? 8'($urandom) : any_letter();
    // mostly legal lengths, now and then zero or beyond the maximum
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
    case ($urandom_range(0, 9))
      0:       off = $urandom_range(0, 65535);
      1, 2:    off = $urandom_range(0, 30);
      default: off = $urandom_range(0, 4);
    endcase
    set_search(pat, 4'(len), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 16'(off));
  endtask

  // idling mix for a phase, including stretches where neither side pauses
  task automatic pick_idling();
    case ($urandom_range(0, 3))
      0: begin quiet_sender = 1'b1; quiet_receiver = 1'b1; end
      1: begin quiet_sender = 1'b1; quiet_receiver = 1'b0; end
      2: begin quiet_sender = 1'b0; quiet_receiver = 1'b1; end
      default: begin quiet_sender = 1'b0; quiet_receiver = 1'b0; end
    endcase
  endtask

  // long output stall while short texts keep coming, so the result register
  // fills and the input side has to back up
  task automatic pressure_phase();
    random_search();
    quiet_sender  = 1'b1;
    long_hold_req = 1'b1;
    repeat (30) send_random_text($urandom_range(1, 3));
    quiet_sender  = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall before every result, one long hold on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      hold = quiet_receiver ? 0 : $urandom_range(0, 10);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LongHoldCycles;
        long_holds_done++;
      end
      @(negedge clk_i);
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and verdict
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned random_from;
    int unsigned phase_from;
    int unsigned phase_n;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: one zero byte, exact, anywhere
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);

    // folded whole-word search: match closed by end of text, match rejected
    // by a following letter, and a text shorter than the pattern
    set_search(pack_pattern("cat"), 4'd3, 1'b0, 1'b1, 16'd0);
    send_string("xCAT");
    send_string("catsCat!");
    send_string("ca");

    // all-ones pattern, length beyond the maximum, one byte folded
    set_search('1, 4'd15, 1'b0, 1'b0, 16'd0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hDF, 1'b0);
    repeat (5) send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);

    // zero length acts as one
    set_search(pack_pattern("Z"), 4'd0, 1'b1, 1'b1, 16'd0);
    send_string("Z");

    // offset near the top of the position range: a short text never gets there
    set_search(pack_pattern("A"), 4'd1, 1'b1, 1'b0, 16'hFFFE);
    send_string("AAAA");

    // random settings and text, with two pressure phases along the way
    random_from = bytes_sent;
    phase_n     = 0;
    while (bytes_sent - random_from < RandomBytes) begin
      if (phase_n == 10 || phase_n == 25) begin
        pressure_phase();
      end else begin
        random_search();
        pick_idling();
        phase_from = bytes_sent;
        while (bytes_sent - phase_from < 40) begin
          if ($urandom_range(0, 4) == 0)
            send_random_text($urandom_range(1, 40));
          else
            send_random_text($urandom_range(1, 12));
        end
      end
      phase_n++;
    end

    settle();
    repeat (10) @(negedge clk_i);

    $display("covered %0d text bytes in %0d texts under %0d register settings,",
             bytes_sent, texts_sent, settings_used);
    $display("checked %0d results (%0d with a match), %0d long receiver holds",
             results_checked, matches_found, long_holds_done);
    if (mismatches == 0 && results_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, results_due);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
